>>> rtl/tvs_pkg.sv
`default_nettype none

package tvs_pkg;

  // Width of the high and low run counters
  localparam int CNT_W = 16;
  localparam int THR_W = 16;
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam int CFG_IDX_W = 8;
  localparam int OUT_W     = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LOW     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = CFG_IDX_W'(3);

  localparam logic [THR_W-1:0] INIT_HIGH_RST    = THR_W'(1000);
  localparam logic [THR_W-1:0] RUNNING_HIGH_RST = THR_W'(10000);
  localparam logic [THR_W-1:0] OPEN_LOW_RST     = THR_W'(5000);
  localparam logic [THR_W-1:0] DEBOUNCE_RST     = THR_W'(50);

  // Operation codes of an input item
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // State codes as reported on the result
  localparam logic [2:0] CODE_INIT              = 3'd0;
  localparam logic [2:0] CODE_INIT_HIGH_WAIT    = 3'd1;
  localparam logic [2:0] CODE_OPEN              = 3'd2;
  localparam logic [2:0] CODE_OPEN_LOW_WAIT     = 3'd3;
  localparam logic [2:0] CODE_RUNNING           = 3'd4;
  localparam logic [2:0] CODE_RUNNING_HIGH_WAIT = 3'd5;

  typedef enum logic [5:0] {
    PH_INIT              = 6'b000001,
    PH_INIT_HIGH_WAIT    = 6'b000010,
    PH_OPEN              = 6'b000100,
    PH_OPEN_LOW_WAIT     = 6'b001000,
    PH_RUNNING           = 6'b010000,
    PH_RUNNING_HIGH_WAIT = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0] init_high;
    logic [THR_W-1:0] running_high;
    logic [THR_W-1:0] open_low;
    logic [THR_W-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       open;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic reached(input logic [CNT_W-1:0] count,
                                   input logic [THR_W-1:0] limit);
    return CMP_W'(count) >= CMP_W'(limit);
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_INIT:              code = CODE_INIT;
      PH_INIT_HIGH_WAIT:    code = CODE_INIT_HIGH_WAIT;
      PH_OPEN:              code = CODE_OPEN;
      PH_OPEN_LOW_WAIT:     code = CODE_OPEN_LOW_WAIT;
      PH_RUNNING:           code = CODE_RUNNING;
      PH_RUNNING_HIGH_WAIT: code = CODE_RUNNING_HIGH_WAIT;
      default:              code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/timed_valve_sequencer_top.sv
`default_nettype none
// Each result is registered into the output register, or into the skid while the output is stalled.
// Throughput: one item per clock while the skid is empty; a one-entry skid keeps s_tready high
// while the output is stalled, so intake stops only with two results held.
// Reset (rst, synchronous): state INIT, counters cleared, valve closed,
// thresholds back to 1000/10000/5000/50, output and skid empty.
module timed_valve_sequencer_top
  import tvs_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [7:0]           s_tdata,   // [0] request_level
  input  wire                  s_tuser,   // [0] operation
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [0] valve_drive_pin, [3:1] current_state,
                                          // [4] valve_is_open
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [THR_W-1:0]     cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t out_res, skid_res;
  logic skid_valid;
  logic in_xfer, out_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_high    <= INIT_HIGH_RST;
      cfg.running_high <= RUNNING_HIGH_RST;
      cfg.open_low     <= OPEN_LOW_RST;
      cfg.debounce     <= DEBOUNCE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INIT_HIGH:    cfg.init_high    <= cfg_data;
        REG_RUNNING_HIGH: cfg.running_high <= cfg_data;
        REG_OPEN_LOW:     cfg.open_low     <= cfg_data;
        REG_DEBOUNCE:     cfg.debounce     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  tvs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (in_xfer),
    .operation     (s_tuser),
    .request_level (s_tdata[0]),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!m_tvalid || out_xfer) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_res <= skid_res;
      end
    end else if (in_xfer) begin
      if (!m_tvalid || out_xfer) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign m_tdata = {3'b000, out_res.open, out_res.state_code, !out_res.open};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a result while output is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_pin_inverse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0] != m_tdata[4])
    else $error("valve pin not inverse of open flag");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:1] != 3'd6 && m_tdata[3:1] != 3'd7)
    else $error("unused state code on output");

endmodule

`default_nettype wire

>>> rtl/tvs_core.sv
`default_nettype none

module tvs_core
  import tvs_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  step,
  input  wire  operation,
  input  wire  request_level,
  input  cfg_t cfg,
  output res_t res
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] high_cnt, high_cnt_next;
  logic [CNT_W-1:0] low_cnt, low_cnt_next;
  logic             open_flag, open_flag_next;

  logic [CNT_W-1:0] high_inc, low_inc;
  logic [THR_W-1:0] open_limit;

  assign high_inc   = sat_inc(high_cnt);
  assign low_inc    = sat_inc(low_cnt);
  assign open_limit = (phase == PH_RUNNING_HIGH_WAIT) ? cfg.running_high : cfg.init_high;

  always_comb begin
    phase_next     = phase;
    high_cnt_next  = high_cnt;
    low_cnt_next   = low_cnt;
    open_flag_next = open_flag;
    if (operation == OP_CLOSE) begin
      phase_next     = PH_INIT;
      high_cnt_next  = '0;
      low_cnt_next   = '0;
      open_flag_next = 1'b0;
    end else begin
      unique case (phase)
        PH_INIT: begin
          if (request_level) begin
            high_cnt_next = CNT_W'(1);
            low_cnt_next  = '0;
            phase_next    = PH_INIT_HIGH_WAIT;
          end else begin
            low_cnt_next  = low_inc;
            high_cnt_next = '0;
          end
        end
        PH_INIT_HIGH_WAIT, PH_RUNNING_HIGH_WAIT: begin
          if (request_level) begin
            high_cnt_next = high_inc;
            low_cnt_next  = '0;
            if (reached(high_inc, open_limit)) begin
              open_flag_next = 1'b1;
              phase_next     = PH_OPEN;
            end
          end else begin
            high_cnt_next = '0;
            low_cnt_next  = low_inc;
            if (reached(low_inc, cfg.debounce)) begin
              low_cnt_next = '0;
              phase_next   = (phase == PH_RUNNING_HIGH_WAIT) ? PH_RUNNING : PH_INIT;
            end
          end
        end
        PH_OPEN: begin
          high_cnt_next = '0;
          low_cnt_next  = '0;
          phase_next    = PH_OPEN_LOW_WAIT;
        end
        PH_OPEN_LOW_WAIT: begin
          if (!request_level) begin
            low_cnt_next  = low_inc;
            high_cnt_next = '0;
            if (reached(low_inc, cfg.open_low)) begin
              open_flag_next = 1'b0;
              phase_next     = PH_RUNNING;
            end
          end else begin
            high_cnt_next = high_inc;
            low_cnt_next  = '0;
            if (reached(high_inc, cfg.debounce)) begin
              phase_next = PH_OPEN;
            end
          end
        end
        PH_RUNNING: begin
          high_cnt_next = '0;
          low_cnt_next  = '0;
          if (request_level) begin
            phase_next = PH_RUNNING_HIGH_WAIT;
          end
        end
        default: begin
          phase_next = PH_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_INIT;
      high_cnt  <= '0;
      low_cnt   <= '0;
      open_flag <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      high_cnt  <= high_cnt_next;
      low_cnt   <= low_cnt_next;
      open_flag <= open_flag_next;
    end
  end

  // Result reflects the state after this item's update
  assign res.state_code = phase_code(phase_next);
  assign res.open       = open_flag_next;

  // valve is commanded open exactly in the two open states
  a_open_matches_phase: assert property (@(posedge clk) disable iff (rst)
    open_flag == ((phase == PH_OPEN) || (phase == PH_OPEN_LOW_WAIT)))
    else $error("open flag disagrees with phase");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    step && operation == OP_CLOSE |=> phase == PH_INIT && high_cnt == '0 && low_cnt == '0)
    else $error("force close did not clear state");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(high_cnt) && $stable(low_cnt))
    else $error("state moved without a transfer");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    high_cnt == '0 || low_cnt == '0)
    else $error("high and low runs both nonzero");

endmodule

`default_nettype wire

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tvs_pkg::*;

  typedef struct packed {
    logic       pin;
    logic [2:0] code;
    logic       opened;
  } valve_report_t;

  // One line of the directed script: a run of identical samples or one register write.
  typedef struct packed {
    logic        is_reg;
    logic [7:0]  sel;     // operation, or register index
    logic [15:0] val;     // request level, or register value
    logic [31:0] reps;
    logic        typed;   // expected report given in the row
    logic [2:0]  code;
    logic        opened;
  } script_row_t;

  localparam logic [7:0]  TICK   = 8'(OP_TICK);
  localparam logic [7:0]  CLOSE  = 8'(OP_CLOSE);
  localparam logic [15:0] LVL_LO = 16'd0;
  localparam logic [15:0] LVL_HI = 16'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hC5;
  localparam int N_ROWS = 28;
  localparam int N_PHASES = 6;
  localparam int PHASE_SAMPLES = 108;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'd0;
  logic s_tuser = 1'b0;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0] cfg_data = '0;
  wire s_tready;
  wire m_tvalid;
  wire [OUT_W-1:0] m_tdata;
  wire cfg_ready;

  timed_valve_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sequencer mirror: thresholds, phase, run counters, valve flag.
  logic [THR_W-1:0] thr_init_high = INIT_HIGH_RST;
  logic [THR_W-1:0] thr_run_high  = RUNNING_HIGH_RST;
  logic [THR_W-1:0] thr_open_low  = OPEN_LOW_RST;
  logic [THR_W-1:0] thr_debounce  = DEBOUNCE_RST;
  logic [2:0]       vs_phase = CODE_INIT;
  logic [CNT_W-1:0] hi_run = '0;
  logic [CNT_W-1:0] lo_run = '0;
  logic             vs_open = 1'b0;

  valve_report_t valve_reports [$];
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;

  script_row_t script [N_ROWS] = '{
    // reset thresholds: 1000 high opens in power-up, 50 debounces
    '{1'b0, CLOSE, LVL_LO, 1,    1'b1, CODE_INIT,              1'b0},
    '{1'b0, TICK,  LVL_LO, 3,    1'b1, CODE_INIT,              1'b0},
    '{1'b0, TICK,  LVL_HI, 1,    1'b1, CODE_INIT_HIGH_WAIT,    1'b0},
    '{1'b0, TICK,  LVL_LO, 49,   1'b1, CODE_INIT_HIGH_WAIT,    1'b0},
    '{1'b0, TICK,  LVL_LO, 1,    1'b1, CODE_INIT,              1'b0},
    '{1'b0, TICK,  LVL_HI, 1,    1'b1, CODE_INIT_HIGH_WAIT,    1'b0},
    '{1'b0, TICK,  LVL_HI, 998,  1'b1, CODE_INIT_HIGH_WAIT,    1'b0},
    '{1'b0, TICK,  LVL_HI, 1,    1'b1, CODE_OPEN,              1'b1},
    '{1'b0, TICK,  LVL_HI, 1,    1'b1, CODE_OPEN_LOW_WAIT,     1'b1},
    '{1'b0, TICK,  LVL_HI, 49,   1'b1, CODE_OPEN_LOW_WAIT,     1'b1},
    '{1'b0, TICK,  LVL_HI, 1,    1'b1, CODE_OPEN,              1'b1},
    '{1'b0, TICK,  LVL_LO, 1,    1'b1, CODE_OPEN_LOW_WAIT,     1'b1},
    '{1'b0, TICK,  LVL_LO, 40,   1'b1, CODE_OPEN_LOW_WAIT,     1'b1},
    '{1'b0, CLOSE, LVL_HI, 1,    1'b1, CODE_INIT,              1'b0},
    // zero and full-scale thresholds, plus a write to an unmapped index
    '{1'b1, REG_INIT_HIGH,    16'd0,     0, 1'b0, CODE_INIT, 1'b0},
    '{1'b1, REG_RUNNING_HIGH, 16'd2,     0, 1'b0, CODE_INIT, 1'b0},
    '{1'b1, REG_OPEN_LOW,     16'hFFFF,  0, 1'b0, CODE_INIT, 1'b0},
    '{1'b1, REG_DEBOUNCE,     16'd1,     0, 1'b0, CODE_INIT, 1'b0},
    '{1'b1, REG_UNMAPPED,     16'd7,     0, 1'b0, CODE_INIT, 1'b0},
    '{1'b0, TICK,  LVL_HI, 2,     1'b0, CODE_INIT,          1'b0},
    '{1'b0, TICK,  LVL_HI, 2,     1'b0, CODE_INIT,          1'b0},
    '{1'b0, TICK,  LVL_LO, 40,    1'b1, CODE_OPEN_LOW_WAIT, 1'b1},
    '{1'b1, REG_OPEN_LOW,     16'd0,     0, 1'b0, CODE_INIT, 1'b0},
    '{1'b0, TICK,  LVL_LO, 1,     1'b1, CODE_RUNNING, 1'b0},
    '{1'b0, TICK,  LVL_HI, 1,     1'b0, CODE_INIT,    1'b0},
    '{1'b0, TICK,  LVL_LO, 1,     1'b0, CODE_INIT,    1'b0},
    '{1'b0, TICK,  LVL_HI, 3,     1'b0, CODE_INIT,    1'b0},
    '{1'b0, CLOSE, LVL_LO, 1,     1'b1, CODE_INIT,    1'b0}
  };

  function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] v);
    return v + CNT_W'(~&v);
  endfunction

  function automatic valve_report_t advance_sequencer(input logic op, input logic lvl);
    logic [THR_W-1:0] open_limit;
    open_limit = (vs_phase == CODE_INIT_HIGH_WAIT) ? thr_init_high : thr_run_high;
    if (op == OP_CLOSE) begin
      vs_phase = CODE_INIT;
      hi_run = '0;
      lo_run = '0;
      vs_open = 1'b0;
    end else begin
      case (vs_phase)
        CODE_INIT: begin
          if (lvl) begin
            hi_run = CNT_W'(1);
            lo_run = '0;
            vs_phase = CODE_INIT_HIGH_WAIT;
          end else begin
            lo_run = cnt_up(lo_run);
            hi_run = '0;
          end
        end
        CODE_INIT_HIGH_WAIT, CODE_RUNNING_HIGH_WAIT: begin
          if (lvl) begin
            hi_run = cnt_up(hi_run);
            lo_run = '0;
            if (hi_run >= open_limit) begin
              vs_open = 1'b1;
              vs_phase = CODE_OPEN;
            end
          end else begin
            lo_run = cnt_up(lo_run);
            hi_run = '0;
            if (lo_run >= thr_debounce) begin
              vs_phase = (vs_phase == CODE_INIT_HIGH_WAIT) ? CODE_INIT : CODE_RUNNING;
              lo_run = '0;
            end
          end
        end
        CODE_OPEN: begin
          hi_run = '0;
          lo_run = '0;
          vs_phase = CODE_OPEN_LOW_WAIT;
        end
        CODE_OPEN_LOW_WAIT: begin
          if (!lvl) begin
            lo_run = cnt_up(lo_run);
            hi_run = '0;
            if (lo_run >= thr_open_low) begin
              vs_open = 1'b0;
              vs_phase = CODE_RUNNING;
            end
          end else begin
            hi_run = cnt_up(hi_run);
            lo_run = '0;
            if (hi_run >= thr_debounce) vs_phase = CODE_OPEN;
          end
        end
        CODE_RUNNING: begin
          hi_run = '0;
          lo_run = '0;
          if (lvl) vs_phase = CODE_RUNNING_HIGH_WAIT;
        end
        default: vs_phase = CODE_INIT;
      endcase
    end
    return '{pin: ~vs_open, code: vs_phase, opened: vs_open};
  endfunction

  // Mostly short limits so the state machine keeps moving; sometimes the extremes.
  function automatic logic [THR_W-1:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 24) return THR_W'($urandom_range(65535));
    return THR_W'($urandom_range(1, 6));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_sample(input logic op, input logic lvl, input logic typed,
                              input logic [2:0] code, input logic opened);
    valve_report_t rep;
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rep = advance_sequencer(op, lvl);
    if (typed) rep = '{pin: ~opened, code: code, opened: opened};
    valve_reports.push_back(rep);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INIT_HIGH:    thr_init_high = val;
      REG_RUNNING_HIGH: thr_run_high  = val;
      REG_OPEN_LOW:     thr_open_low  = val;
      REG_DEBOUNCE:     thr_debounce  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (valve_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 32);

  always @(posedge clk) begin : watch
    valve_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (valve_reports.size() == 0) begin
        $display("%0t ns: result %h with nothing expected", $time, m_tdata);
        mismatches++;
      end else begin
        want = valve_reports.pop_front();
        if (m_tdata[0] !== want.pin) begin
          $display("%0t ns: valve_drive_pin expected %0b got %0b", $time, want.pin, m_tdata[0]);
          mismatches++;
        end
        if (m_tdata[3:1] !== want.code) begin
          $display("%0t ns: current_state expected %0d got %0d", $time, want.code, m_tdata[3:1]);
          mismatches++;
        end
        if (m_tdata[4] !== want.opened) begin
          $display("%0t ns: valve_is_open expected %0b got %0b", $time, want.opened, m_tdata[4]);
          mismatches++;
        end
        if (m_tdata[OUT_W-1:5] !== '0) begin
          $display("%0t ns: tdata padding expected 0 got %h", $time, m_tdata[OUT_W-1:5]);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int sent;
    int n;
    int r;
    int run_cap;
    int directed_count;
    logic lvl;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].sel, script[i].val);
      end else begin
        repeat (script[i].reps)
          offer_sample(script[i].sel[0], script[i].val[0], script[i].typed,
                       script[i].code, script[i].opened);
      end
    end
    directed_count = samples_sent;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      calm = (ph == 2);
      write_reg(REG_INIT_HIGH, pick_limit());
      write_reg(REG_RUNNING_HIGH, pick_limit());
      write_reg(REG_OPEN_LOW, pick_limit());
      write_reg(REG_DEBOUNCE, pick_limit());
      if ($urandom_range(1)) write_reg(CFG_IDX_W'($urandom_range(4, 255)), THR_W'($urandom));
      settings_used++;
      run_cap = $urandom_range(3, 10);
      sent = 0;
      // level runs drive the thresholds; closes and lone samples break them up
      while (sent < PHASE_SAMPLES) begin
        r = $urandom_range(99);
        if (r < 4) begin
          offer_sample(OP_CLOSE, 1'($urandom_range(1)), 1'b0, CODE_INIT, 1'b0);
          sent++;
        end else if (r < 12) begin
          offer_sample(OP_TICK, 1'($urandom_range(1)), 1'b0, CODE_INIT, 1'b0);
          sent++;
        end else begin
          lvl = 1'($urandom_range(1));
          n = $urandom_range(1, run_cap);
          repeat (n) offer_sample(OP_TICK, lvl, 1'b0, CODE_INIT, 1'b0);
          sent += n;
        end
      end
    end
    calm = 1'b0;

    settle();
    repeat (4) @(negedge clk);
    $display("Run covered %0d sample transfers (%0d directed: runs to the reset limits,",
             samples_sent, directed_count);
    $display("zero and full-scale limits) and %0d random threshold sets; %0d results checked.",
             settings_used, results_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Far beyond the longest legal run with full idling on both sides.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
